/* hdl/obb_pkg.sv */
// Shared constants, types and sine polynomial coefficients for the oriented box overlap core.
package obb_pkg;

   // Field widths
   localparam int POS_BITS   = 24;
   localparam int ANGLE_BITS = 16;
   localparam int HALF_W     = 16;
   localparam int TRIG_W     = 16;
   localparam int DEPTH_W    = 24;
   localparam int TURN_W     = 16;
   localparam int NUM_AXES   = 4;
   localparam int NUM_BOXES  = 2;

   // Pipeline depths
   localparam int SIN_STAGES  = 4;
   localparam int PROJ_STAGES = 4;

   // Sine polynomial, Q1.14
   localparam int Z_W = 15;
   localparam logic [Z_W-1:0] Z_ONE = 15'd16384;
   localparam logic [Z_W-1:0] SIN_A = 15'd25736;
   localparam logic [13:0]    SIN_B = 14'd10512;
   localparam logic [10:0]    SIN_C = 11'd1160;

   // Projection arithmetic
   localparam int UV_W         = 2 * TRIG_W + 1;
   localparam int MAG_W        = 30;
   localparam int PC_W         = POS_BITS + TRIG_W + 1;
   localparam int CENTER_SHIFT = 14;
   localparam int CTR_W        = PC_W + CENTER_SHIFT;
   localparam int EXT_W        = HALF_W + MAG_W + 1;
   localparam int PROJ_W       = CTR_W + 3;
   localparam int DEPTH_SHIFT  = 28;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   typedef struct packed {
      logic signed [POS_BITS-1:0] cx;
      logic signed [POS_BITS-1:0] cy;
      logic [HALF_W-1:0]          hw;
      logic [HALF_W-1:0]          hh;
   } box_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_type;

   typedef struct packed {
      logic              sep;
      logic              flip;
      logic [PROJ_W-1:0] depth;
   } axis_res_type;

endpackage

/* hdl/obb_if.sv */
// Request and response channel interfaces for the oriented box overlap core.
interface obb_req_if;
   import obb_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [POS_BITS-1:0]   a_center_x;
   logic signed [POS_BITS-1:0]   a_center_y;
   logic [ANGLE_BITS-1:0]        a_angle;
   logic [HALF_W-1:0]            a_half_width;
   logic [HALF_W-1:0]            a_half_height;
   logic signed [POS_BITS-1:0]   b_center_x;
   logic signed [POS_BITS-1:0]   b_center_y;
   logic [ANGLE_BITS-1:0]        b_angle;
   logic [HALF_W-1:0]            b_half_width;
   logic [HALF_W-1:0]            b_half_height;

   modport source (output valid, a_center_x, a_center_y, a_angle, a_half_width,
                   a_half_height, b_center_x, b_center_y, b_angle, b_half_width,
                   b_half_height, input ready);
   modport sink (input valid, a_center_x, a_center_y, a_angle, a_half_width,
                 a_half_height, b_center_x, b_center_y, b_angle, b_half_width,
                 b_half_height, output ready);
endinterface

interface obb_rsp_if;
   import obb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       collides;
   logic signed [TRIG_W-1:0]   normal_x;
   logic signed [TRIG_W-1:0]   normal_y;
   logic [DEPTH_W-1:0]         depth;

   modport source (output valid, collides, normal_x, normal_y, depth, input ready);
   modport sink (input valid, collides, normal_x, normal_y, depth, output ready);
endinterface

/* hdl/obb_sat_overlap_test_core.sv */
// Top level of the oriented box separating axis overlap core.
// One box pair is accepted every clock cycle while the pipeline advances;
// it passes four stages of the sine polynomial, four stages of axis projection
// (products, extents, interval ends, gap and depth), then one stage that picks
// the least overlap axis and registers the result beat. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// a stall on the response side holds every stage and drops nothing.
module obb_sat_overlap_test_core (
   input logic      clock,
   input logic      reset,
   obb_req_if.sink  req_bus,
   obb_rsp_if.source rsp_bus
);
   import obb_pkg::*;

   localparam int FRONT_STAGES = SIN_STAGES + PROJ_STAGES;

   logic                     en;
   logic                     out_valid;
   logic [FRONT_STAGES-1:0]  valid_ff;
   box_type                  box_a_in, box_b_in;
   box_type                  box_a_ff [SIN_STAGES];
   box_type                  box_b_ff [SIN_STAGES];
   logic [TURN_W-1:0]        ta, tb, ta_c, tb_c;
   logic signed [TRIG_W-1:0] sa, ca, sb, cb;
   box_type                  boxes [NUM_BOXES];
   trig_type                 trigs [NUM_BOXES];
   logic signed [TRIG_W-1:0] axis_x [NUM_AXES];
   logic signed [TRIG_W-1:0] axis_y [NUM_AXES];
   axis_res_type             res [NUM_AXES];
   logic signed [TRIG_W-1:0] nrm_x [NUM_AXES];
   logic signed [TRIG_W-1:0] nrm_y [NUM_AXES];

   // pipeline advance
   assign en            = !out_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], req_bus.valid};
      end
   end

   // box payload rides along with the sine stages
   assign box_a_in = '{cx: req_bus.a_center_x, cy: req_bus.a_center_y,
                       hw: req_bus.a_half_width, hh: req_bus.a_half_height};
   assign box_b_in = '{cx: req_bus.b_center_x, cy: req_bus.b_center_y,
                       hw: req_bus.b_half_width, hh: req_bus.b_half_height};

   always_ff @(posedge clock) begin
      if (en) begin
         box_a_ff[0] <= box_a_in;
         box_b_ff[0] <= box_b_in;
         for (int i = 1; i < SIN_STAGES; i++) begin
            box_a_ff[i] <= box_a_ff[i-1];
            box_b_ff[i] <= box_b_ff[i-1];
         end
      end
   end

   // angles to 16-bit turns; cosine is a quarter turn ahead
   assign ta   = TURN_W'(req_bus.a_angle) << (TURN_W - ANGLE_BITS);
   assign tb   = TURN_W'(req_bus.b_angle) << (TURN_W - ANGLE_BITS);
   assign ta_c = ta + TURN_W'(1 << (TURN_W - 2));
   assign tb_c = tb + TURN_W'(1 << (TURN_W - 2));

   obb_sin u_sin_a (.clock(clock), .en(en), .turn(ta),   .sin_out(sa));
   obb_sin u_cos_a (.clock(clock), .en(en), .turn(ta_c), .sin_out(ca));
   obb_sin u_sin_b (.clock(clock), .en(en), .turn(tb),   .sin_out(sb));
   obb_sin u_cos_b (.clock(clock), .en(en), .turn(tb_c), .sin_out(cb));

   // axes: A's y, A's x, B's y, B's x
   assign boxes[0] = box_a_ff[SIN_STAGES-1];
   assign boxes[1] = box_b_ff[SIN_STAGES-1];
   assign trigs[0] = '{s: sa, c: ca};
   assign trigs[1] = '{s: sb, c: cb};
   assign axis_x[0] = -sa;
   assign axis_y[0] = ca;
   assign axis_x[1] = ca;
   assign axis_y[1] = sa;
   assign axis_x[2] = -sb;
   assign axis_y[2] = cb;
   assign axis_x[3] = cb;
   assign axis_y[3] = sb;

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
      obb_axis_proj u_proj (
         .clock  (clock),
         .en     (en),
         .axis_x (axis_x[k]),
         .axis_y (axis_y[k]),
         .box    (boxes),
         .trig   (trigs),
         .res    (res[k]),
         .norm_x (nrm_x[k]),
         .norm_y (nrm_y[k])
      );
   end

   obb_select u_select (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_ff[FRONT_STAGES-1]),
      .res       (res),
      .ax        (nrm_x),
      .ay        (nrm_y),
      .out_valid (out_valid),
      .collides  (rsp_bus.collides),
      .normal_x  (rsp_bus.normal_x),
      .normal_y  (rsp_bus.normal_y),
      .depth     (rsp_bus.depth)
   );

   assign rsp_bus.valid = out_valid;

   // no beat comes out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   // a miss carries a zero normal and zero depth
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.collides |->
         rsp_bus.normal_x == '0 && rsp_bus.normal_y == '0 && rsp_bus.depth == '0)
      else $error("miss with nonzero normal or depth");

   // a hit normal stays within one unit
   a_hit_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.collides |->
         rsp_bus.normal_x <= 16'sd16384 && rsp_bus.normal_x >= -16'sd16384 &&
         rsp_bus.normal_y <= 16'sd16384 && rsp_bus.normal_y >= -16'sd16384)
      else $error("normal outside unit range");

   // a stalled pipeline keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");
endmodule

/* hdl/obb_sin.sv */
// Four-stage fixed-point sine of a 16-bit turn, Q1.14 result.
module obb_sin (
   input  logic                              clock,
   input  logic                              en,
   input  logic [obb_pkg::TURN_W-1:0]        turn,
   output logic signed [obb_pkg::TRIG_W-1:0] sin_out
);
   import obb_pkg::*;

   logic [1:0]       quad;
   logic [13:0]      r;
   logic [Z_W-1:0]   z_in;
   logic [2*Z_W-1:0] zz;
   logic [Z_W-1:0]   z1_ff, z2_1_ff;
   logic             neg1_ff;
   logic [25:0]      mc;
   logic [Z_W-1:0]   z2_ff, z2_2_ff;
   logic [10:0]      m1_ff;
   logic             neg2_ff;
   logic [13:0]      inner;
   logic [28:0]      pz;
   logic [Z_W-1:0]   poly_in;
   logic [Z_W-1:0]   z3_ff, poly_ff;
   logic             neg3_ff;
   logic [2*Z_W-1:0] ps;
   logic signed [TRIG_W:0] mag;
   logic signed [TRIG_W-1:0] sin_ff;

   // stage 1: fold quadrant, square
   assign quad = turn[TURN_W-1 -: 2];
   assign r    = turn[13:0];
   assign z_in = quad[0] ? Z_W'(Z_ONE - {1'b0, r}) : {1'b0, r};
   assign zz   = z_in * z_in;

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff   <= z_in;
         z2_1_ff <= zz[28:14];
         neg1_ff <= quad[1];
      end
   end

   // stage 2: innermost term
   assign mc = z2_1_ff * SIN_C;

   always_ff @(posedge clock) begin
      if (en) begin
         z2_ff   <= z1_ff;
         z2_2_ff <= z2_1_ff;
         m1_ff   <= mc[24:14];
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: middle term
   assign inner   = SIN_B - {3'b0, m1_ff};
   assign pz      = z2_2_ff * inner;
   assign poly_in = SIN_A - {1'b0, pz[27:14]};

   always_ff @(posedge clock) begin
      if (en) begin
         z3_ff   <= z2_ff;
         poly_ff <= poly_in;
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: final product and sign
   assign ps  = z3_ff * poly_ff;
   assign mag = $signed({1'b0, ps[29:14]});

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= TRIG_W'(neg3_ff ? -mag : mag);
      end
   end

   assign sin_out = sin_ff;
endmodule

/* hdl/obb_axis_proj.sv */
// Four-stage projection of both boxes onto one axis: interval test and overlap depth.
module obb_axis_proj (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [obb_pkg::TRIG_W-1:0] axis_x,
   input  logic signed [obb_pkg::TRIG_W-1:0] axis_y,
   input  obb_pkg::box_type                  box [obb_pkg::NUM_BOXES],
   input  obb_pkg::trig_type                 trig [obb_pkg::NUM_BOXES],
   output obb_pkg::axis_res_type             res,
   output logic signed [obb_pkg::TRIG_W-1:0] norm_x,
   output logic signed [obb_pkg::TRIG_W-1:0] norm_y
);
   import obb_pkg::*;

   logic signed [2*TRIG_W-1:0]         cu_x [NUM_BOXES];
   logic signed [2*TRIG_W-1:0]         cu_y [NUM_BOXES];
   logic signed [2*TRIG_W-1:0]         cv_x [NUM_BOXES];
   logic signed [2*TRIG_W-1:0]         cv_y [NUM_BOXES];
   logic signed [POS_BITS+TRIG_W-1:0]  pc_x [NUM_BOXES];
   logic signed [POS_BITS+TRIG_W-1:0]  pc_y [NUM_BOXES];
   logic signed [UV_W-1:0]             u_in [NUM_BOXES];
   logic signed [UV_W-1:0]             v_in [NUM_BOXES];
   logic signed [PC_W-1:0]             pc_in [NUM_BOXES];
   logic signed [UV_W-1:0]             u_ff [NUM_BOXES];
   logic signed [UV_W-1:0]             v_ff [NUM_BOXES];
   logic signed [PC_W-1:0]             pc_ff [NUM_BOXES];
   logic [HALF_W-1:0]                  hw_ff [NUM_BOXES];
   logic [HALF_W-1:0]                  hh_ff [NUM_BOXES];
   logic signed [UV_W-1:0]             mu [NUM_BOXES];
   logic signed [UV_W-1:0]             mv [NUM_BOXES];
   logic [HALF_W+MAG_W-1:0]            eu [NUM_BOXES];
   logic [HALF_W+MAG_W-1:0]            ev [NUM_BOXES];
   logic [EXT_W-1:0]                   ext_in [NUM_BOXES];
   logic [EXT_W-1:0]                   ext_ff [NUM_BOXES];
   logic signed [CTR_W-1:0]            ctr_ff [NUM_BOXES];
   logic signed [PROJ_W-1:0]           lo_in [NUM_BOXES];
   logic signed [PROJ_W-1:0]           hi_in [NUM_BOXES];
   logic signed [PROJ_W-1:0]           lo_ff [NUM_BOXES];
   logic signed [PROJ_W-1:0]           hi_ff [NUM_BOXES];
   logic                               flip_ff;
   logic signed [PROJ_W-1:0]           ov_lo, ov_hi;
   axis_res_type                       res_in, res_ff;
   logic signed [TRIG_W-1:0]           ax_ff [PROJ_STAGES];
   logic signed [TRIG_W-1:0]           ay_ff [PROJ_STAGES];

   // stage 1: rotated extent factors and center projection
   always_comb begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         cu_x[i]  = $signed(trig[i].c) * axis_x;
         cu_y[i]  = $signed(trig[i].s) * axis_y;
         cv_x[i]  = $signed(trig[i].s) * axis_x;
         cv_y[i]  = $signed(trig[i].c) * axis_y;
         pc_x[i]  = $signed(box[i].cx) * axis_x;
         pc_y[i]  = $signed(box[i].cy) * axis_y;
         u_in[i]  = UV_W'(cu_x[i]) + UV_W'(cu_y[i]);
         v_in[i]  = UV_W'(cv_y[i]) - UV_W'(cv_x[i]);
         pc_in[i] = PC_W'(pc_x[i]) + PC_W'(pc_y[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_BOXES; i++) begin
            u_ff[i]  <= u_in[i];
            v_ff[i]  <= v_in[i];
            pc_ff[i] <= pc_in[i];
            hw_ff[i] <= box[i].hw;
            hh_ff[i] <= box[i].hh;
         end
      end
   end

   // stage 2: half extent along the axis, center scaled to corner precision
   always_comb begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         mu[i]     = u_ff[i][UV_W-1] ? -u_ff[i] : u_ff[i];
         mv[i]     = v_ff[i][UV_W-1] ? -v_ff[i] : v_ff[i];
         eu[i]     = hw_ff[i] * mu[i][MAG_W-1:0];
         ev[i]     = hh_ff[i] * mv[i][MAG_W-1:0];
         ext_in[i] = EXT_W'(eu[i]) + EXT_W'(ev[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_BOXES; i++) begin
            ext_ff[i] <= ext_in[i];
            ctr_ff[i] <= $signed({pc_ff[i], {CENTER_SHIFT{1'b0}}});
         end
      end
   end

   // stage 3: interval ends; normal faces B when B's center projects lower
   always_comb begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         lo_in[i] = PROJ_W'(ctr_ff[i]) - $signed(PROJ_W'(ext_ff[i]));
         hi_in[i] = PROJ_W'(ctr_ff[i]) + $signed(PROJ_W'(ext_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_BOXES; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
         flip_ff <= ctr_ff[1] < ctr_ff[0];
      end
   end

   // stage 4: gap test and overlap depth
   always_comb begin
      ov_lo        = (lo_ff[0] > lo_ff[1]) ? lo_ff[0] : lo_ff[1];
      ov_hi        = (hi_ff[0] < hi_ff[1]) ? hi_ff[0] : hi_ff[1];
      res_in.sep   = !(lo_ff[0] <= hi_ff[1] && lo_ff[1] <= hi_ff[0]);
      res_in.flip  = flip_ff;
      res_in.depth = ov_hi - ov_lo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   // axis travels alongside the projection
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff[0] <= axis_x;
         ay_ff[0] <= axis_y;
         for (int i = 1; i < PROJ_STAGES; i++) begin
            ax_ff[i] <= ax_ff[i-1];
            ay_ff[i] <= ay_ff[i-1];
         end
      end
   end

   assign res    = res_ff;
   assign norm_x = ax_ff[PROJ_STAGES-1];
   assign norm_y = ay_ff[PROJ_STAGES-1];
endmodule

/* hdl/obb_select.sv */
// Least-depth axis pick, normal orientation, depth saturation and output register.
module obb_select (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  obb_pkg::axis_res_type             res [obb_pkg::NUM_AXES],
   input  logic signed [obb_pkg::TRIG_W-1:0] ax [obb_pkg::NUM_AXES],
   input  logic signed [obb_pkg::TRIG_W-1:0] ay [obb_pkg::NUM_AXES],
   output logic                              out_valid,
   output logic                              collides,
   output logic signed [obb_pkg::TRIG_W-1:0] normal_x,
   output logic signed [obb_pkg::TRIG_W-1:0] normal_y,
   output logic [obb_pkg::DEPTH_W-1:0]       depth
);
   import obb_pkg::*;

   logic                     any_sep;
   logic [PROJ_W-1:0]        best;
   logic                     best_flip;
   logic signed [TRIG_W-1:0] bx, by;
   logic [PROJ_W-DEPTH_SHIFT-1:0] dsh;
   logic                     hit_in;
   logic signed [TRIG_W-1:0] nx_in, ny_in;
   logic [DEPTH_W-1:0]       d_in;
   logic                     valid_ff;
   logic                     hit_ff;
   logic signed [TRIG_W-1:0] nx_ff, ny_ff;
   logic [DEPTH_W-1:0]       d_ff;

   // first axis wins ties
   always_comb begin
      any_sep   = 1'b0;
      best      = res[0].depth;
      best_flip = res[0].flip;
      bx        = ax[0];
      by        = ay[0];
      for (int k = 0; k < NUM_AXES; k++) begin
         any_sep = any_sep | res[k].sep;
      end
      for (int k = 1; k < NUM_AXES; k++) begin
         if (res[k].depth < best) begin
            best      = res[k].depth;
            best_flip = res[k].flip;
            bx        = ax[k];
            by        = ay[k];
         end
      end
      dsh    = best[PROJ_W-1:DEPTH_SHIFT];
      hit_in = !any_sep;
      nx_in  = hit_in ? (best_flip ? -bx : bx) : '0;
      ny_in  = hit_in ? (best_flip ? -by : by) : '0;
      if (!hit_in) begin
         d_in = '0;
      end else if (|dsh[PROJ_W-DEPTH_SHIFT-1:DEPTH_W]) begin
         d_in = DEPTH_MAX;
      end else begin
         d_in = dsh[DEPTH_W-1:0];
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         d_ff   <= d_in;
      end
   end

   assign out_valid = valid_ff;
   assign collides  = hit_ff;
   assign normal_x  = nx_ff;
   assign normal_y  = ny_ff;
   assign depth     = d_ff;
endmodule
